>>> rtl/bfsp_pkg.sv
package bfsp_pkg;

   // Field widths fixed by the stream formats
   localparam int VID_W      = 7;
   localparam int WGT_W      = 16;
   localparam int DIST_W     = 24;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 1;

   localparam int MAX_VERTICES_DEFAULT = 64;

   // Weight / distance markers
   localparam logic [WGT_W-1:0]  INF_WGT  = 16'd999;
   localparam logic [DIST_W-1:0] INF_DIST = 24'd999;
   localparam logic [DIST_W-1:0] DIST_MAX = 24'h7FFFFF;
   localparam logic [DIST_W-1:0] DIST_MIN = 24'h800000;

   // Request kinds (tuser)
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SOLVE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_VERTEX = 1'd1;

   // Microprogram step addresses
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SEED   = 4'd1;
   localparam logic [3:0] ST_SDRAIN = 4'd2;
   localparam logic [3:0] ST_VINIT  = 4'd3;
   localparam logic [3:0] ST_VCHK   = 4'd4;
   localparam logic [3:0] ST_VLOAD  = 4'd5;
   localparam logic [3:0] ST_ULOOP  = 4'd6;
   localparam logic [3:0] ST_UDRAIN = 4'd7;
   localparam logic [3:0] ST_VWB    = 4'd8;
   localparam logic [3:0] ST_VNEXT  = 4'd9;
   localparam logic [3:0] ST_KNEXT  = 4'd10;
   localparam logic [3:0] ST_OINIT  = 4'd11;
   localparam logic [3:0] ST_ORD    = 4'd12;
   localparam logic [3:0] ST_OEMIT  = 4'd13;
   localparam logic [3:0] ST_RET    = 4'd14;

   // Counter operations
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_INC  = 2'd2;

   // Memory read selections
   localparam logic [2:0] RD_NONE   = 3'd0;
   localparam logic [2:0] RD_SEED   = 3'd1;
   localparam logic [2:0] RD_RELAX  = 3'd2;
   localparam logic [2:0] RD_DIST_V = 3'd3;
   localparam logic [2:0] RD_OUT    = 3'd4;

   // Jump conditions
   localparam logic [2:0] JC_NONE    = 3'd0;
   localparam logic [2:0] JC_ALWAYS  = 3'd1;
   localparam logic [2:0] JC_SOLVE   = 3'd2;
   localparam logic [2:0] JC_NLAST_U = 3'd3;
   localparam logic [2:0] JC_NLAST_V = 3'd4;
   localparam logic [2:0] JC_NLAST_K = 3'd5;
   localparam logic [2:0] JC_N_ONE   = 3'd6;
   localparam logic [2:0] JC_V_IS_S  = 3'd7;

   typedef struct packed {
      logic       idle;
      logic       wait_out;
      logic [1:0] u_op;
      logic [1:0] v_op;
      logic [1:0] k_op;
      logic [2:0] rd_sel;
      logic       load_best;
      logic       write_back;
      logic       emit;
      logic [2:0] cond;
      logic [3:0] target;
   } ucode_type;

   typedef struct packed {
      logic             idle;
      logic [2:0]       rd_sel;
      logic             load_best;
      logic             write_back;
      logic             emit;
      logic [VID_W-1:0] u;
      logic [VID_W-1:0] v;
      logic [VID_W-1:0] n;
      logic [VID_W-1:0] s;
   } dp_ctrl_type;

   // Control store
   function automatic ucode_type ucode_rom(input logic [3:0] pc);
      ucode_type cw;
      cw = '0;
      unique case (pc)
         ST_IDLE: begin
            cw.idle = 1'b1; cw.u_op = CNT_ONE;
            cw.cond = JC_SOLVE; cw.target = ST_SEED;
         end
         ST_SEED: begin
            cw.rd_sel = RD_SEED; cw.u_op = CNT_INC;
            cw.cond = JC_NLAST_U; cw.target = ST_SEED;
         end
         ST_SDRAIN: begin
            cw.k_op = CNT_ONE; cw.cond = JC_N_ONE; cw.target = ST_OINIT;
         end
         ST_VINIT: begin
            cw.v_op = CNT_ONE;
         end
         ST_VCHK: begin
            cw.rd_sel = RD_DIST_V; cw.u_op = CNT_ONE;
            cw.cond = JC_V_IS_S; cw.target = ST_VNEXT;
         end
         ST_VLOAD: begin
            cw.load_best = 1'b1;
         end
         ST_ULOOP: begin
            cw.rd_sel = RD_RELAX; cw.u_op = CNT_INC;
            cw.cond = JC_NLAST_U; cw.target = ST_ULOOP;
         end
         ST_UDRAIN: begin
            cw.cond = JC_NONE;
         end
         ST_VWB: begin
            cw.write_back = 1'b1;
         end
         ST_VNEXT: begin
            cw.v_op = CNT_INC; cw.cond = JC_NLAST_V; cw.target = ST_VCHK;
         end
         ST_KNEXT: begin
            cw.k_op = CNT_INC; cw.cond = JC_NLAST_K; cw.target = ST_VINIT;
         end
         ST_OINIT: begin
            cw.u_op = CNT_ONE;
         end
         ST_ORD: begin
            cw.rd_sel = RD_OUT;
         end
         ST_OEMIT: begin
            cw.wait_out = 1'b1; cw.rd_sel = RD_OUT; cw.u_op = CNT_INC;
            cw.emit = 1'b1; cw.cond = JC_NLAST_U; cw.target = ST_ORD;
         end
         ST_RET: begin
            cw.cond = JC_ALWAYS; cw.target = ST_IDLE;
         end
         default: begin
            cw.cond = JC_ALWAYS; cw.target = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

>>> rtl/bfsp_ram.sv
module bfsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/bfsp_seq.sv
module bfsp_seq #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_opcode,
   input  logic [bfsp_pkg::VID_W-1:0]    cfg_vertex_count,
   input  logic [bfsp_pkg::VID_W-1:0]    cfg_source_vertex,
   input  logic                          out_busy,
   output bfsp_pkg::dp_ctrl_type         ctrl
);

   localparam int VW = bfsp_pkg::VID_W;

   bfsp_pkg::ucode_type cw;
   logic [3:0]    pc_ff, pc_in;
   logic [VW-1:0] u_ff, u_in, v_ff, v_in, k_ff, k_in;
   logic [VW-1:0] n_ff, n_in, s_ff, s_in;
   logic [VW-1:0] n_eff, s_eff;
   logic          stall, take;

   assign cw    = bfsp_pkg::ucode_rom(pc_ff);
   assign stall = cw.wait_out & out_busy;

   // clamp configuration into the usable range
   always_comb begin
      if (cfg_vertex_count == '0) begin
         n_eff = VW'(1);
      end else if (32'(cfg_vertex_count) > MAX_VERTICES) begin
         n_eff = VW'(MAX_VERTICES);
      end else begin
         n_eff = cfg_vertex_count;
      end
      if (cfg_source_vertex == '0) begin
         s_eff = VW'(1);
      end else if (cfg_source_vertex > n_eff) begin
         s_eff = n_eff;
      end else begin
         s_eff = cfg_source_vertex;
      end
   end

   always_comb begin
      unique case (cw.cond)
         bfsp_pkg::JC_NONE:    take = 1'b0;
         bfsp_pkg::JC_ALWAYS:  take = 1'b1;
         bfsp_pkg::JC_SOLVE:   take = req_tvalid & (req_opcode == bfsp_pkg::OP_SOLVE);
         bfsp_pkg::JC_NLAST_U: take = (u_ff != n_ff);
         bfsp_pkg::JC_NLAST_V: take = (v_ff != n_ff);
         bfsp_pkg::JC_NLAST_K: take = (k_ff != VW'(n_ff - VW'(1)));
         bfsp_pkg::JC_N_ONE:   take = (n_ff == VW'(1));
         bfsp_pkg::JC_V_IS_S:  take = (v_ff == s_ff);
         default:              take = 1'b0;
      endcase
   end

   function automatic logic [VW-1:0] cnt_next(input logic [1:0] op, input logic [VW-1:0] c);
      logic [VW-1:0] r;
      unique case (op)
         bfsp_pkg::CNT_ONE: r = VW'(1);
         bfsp_pkg::CNT_INC: r = VW'(c + VW'(1));
         default:           r = c;
      endcase
      return r;
   endfunction

   always_comb begin
      pc_in = pc_ff;
      u_in  = u_ff;
      v_in  = v_ff;
      k_in  = k_ff;
      n_in  = n_ff;
      s_in  = s_ff;
      if (!stall) begin
         // hold the idle step until a solve arrives
         pc_in = take ? cw.target : (cw.idle ? pc_ff : 4'(pc_ff + 4'd1));
         u_in  = cnt_next(cw.u_op, u_ff);
         v_in  = cnt_next(cw.v_op, v_ff);
         k_in  = cnt_next(cw.k_op, k_ff);
      end
      // capture the run's geometry as the solve is taken
      if (cw.idle && take) begin
         n_in = n_eff;
         s_in = s_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bfsp_pkg::ST_IDLE;
         u_ff  <= VW'(1);
         v_ff  <= VW'(1);
         k_ff  <= VW'(1);
         n_ff  <= VW'(1);
         s_ff  <= VW'(1);
      end else begin
         pc_ff <= pc_in;
         u_ff  <= u_in;
         v_ff  <= v_in;
         k_ff  <= k_in;
         n_ff  <= n_in;
         s_ff  <= s_in;
      end
   end

   always_comb begin
      ctrl            = '0;
      ctrl.idle       = cw.idle;
      ctrl.rd_sel     = cw.rd_sel;
      ctrl.load_best  = cw.load_best;
      ctrl.write_back = cw.write_back;
      ctrl.emit       = cw.emit & ~stall;
      ctrl.u          = u_ff;
      ctrl.v          = v_ff;
      ctrl.n          = n_ff;
      ctrl.s          = s_ff;
   end

   a_uloop_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == bfsp_pkg::ST_ULOOP) |-> (u_ff >= VW'(1) && u_ff <= n_ff))
      else $error("tail index out of range in relaxation loop");

   a_source_skipped: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == bfsp_pkg::ST_VLOAD) |-> (v_ff != s_ff))
      else $error("source vertex entered relaxation");

   a_source_in_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff != bfsp_pkg::ST_IDLE) |-> (s_ff >= VW'(1) && s_ff <= n_ff))
      else $error("source outside vertex range during run");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == bfsp_pkg::ST_OEMIT && out_busy) |=>
         (pc_ff == bfsp_pkg::ST_OEMIT && $stable(u_ff)))
      else $error("result step advanced while output was blocked");

endmodule

>>> rtl/bfsp_dp.sv
module bfsp_dp #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bfsp_pkg::dp_ctrl_type               ctrl,
   input  logic                                req_tvalid,
   input  logic                                req_tuser,
   input  logic [bfsp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [bfsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                out_busy
);

   localparam int VW    = bfsp_pkg::VID_W;
   localparam int WW    = bfsp_pkg::WGT_W;
   localparam int DW    = bfsp_pkg::DIST_W;
   localparam int MDEP  = MAX_VERTICES * MAX_VERTICES;
   localparam int MAW   = $clog2(MDEP);
   localparam int VAW   = $clog2(MAX_VERTICES);
   localparam int PAD_W = bfsp_pkg::RSP_DATA_W - 2 * VW - DW;

   localparam logic [1:0] PK_NONE  = 2'd0;
   localparam logic [1:0] PK_SEED  = 2'd1;
   localparam logic [1:0] PK_RELAX = 2'd2;

   // request fields
   logic [VW-1:0] ld_row, ld_col;
   logic [WW-1:0] ld_wgt;
   logic          ld_ok;

   logic          mat_we;
   logic [MAW-1:0] mat_waddr, mat_raddr;
   logic [WW-1:0] mat_rdata;
   logic [VW-1:0] rd_row, rd_col;

   logic          dist_we;
   logic [VAW-1:0] dist_waddr, dist_raddr;
   logic [DW-1:0] dist_wdata, dist_rdata;
   logic [VW-1:0] pred_wdata, pred_rdata;
   logic [VAW-1:0] pred_raddr;

   logic [1:0]    pend_ff, pend_in;
   logic [VW-1:0] pend_idx_ff;
   logic [DW-1:0] best_ff, best_in;
   logic [VW-1:0] bestp_ff, bestp_in;
   logic          upd_ff, upd_in;

   logic [DW-1:0] du, sat;
   logic [DW:0]   sum;
   logic          usable;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [bfsp_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [VW-1:0] pred_out;

   assign ld_row = req_tdata[VW-1:0];
   assign ld_col = req_tdata[2*VW-1:VW];
   assign ld_wgt = req_tdata[2*VW+WW-1:2*VW];
   assign ld_ok  = (ld_row != '0) && (32'(ld_row) <= MAX_VERTICES) &&
                   (ld_col != '0) && (32'(ld_col) <= MAX_VERTICES);

   // weight matrix: loads write, seed and relaxation read
   assign mat_we    = ctrl.idle & req_tvalid & (req_tuser == bfsp_pkg::OP_LOAD) & ld_ok;
   assign mat_waddr = MAW'((32'(ld_row) - 32'd1) * MAX_VERTICES + (32'(ld_col) - 32'd1));
   assign rd_row    = (ctrl.rd_sel == bfsp_pkg::RD_SEED) ? ctrl.s : ctrl.u;
   assign rd_col    = (ctrl.rd_sel == bfsp_pkg::RD_SEED) ? ctrl.u : ctrl.v;
   assign mat_raddr = MAW'((32'(rd_row) - 32'd1) * MAX_VERTICES + (32'(rd_col) - 32'd1));

   bfsp_ram #(.WIDTH(WW), .DEPTH(MDEP)) u_mat (
      .clock (clock),
      .we    (mat_we),
      .waddr (mat_waddr),
      .wdata (ld_wgt),
      .raddr (mat_raddr),
      .rdata (mat_rdata)
   );

   // distance and predecessor tables share a write strobe
   assign dist_we    = (pend_ff == PK_SEED) | (ctrl.write_back & upd_ff);
   assign dist_waddr = (pend_ff == PK_SEED) ? VAW'(pend_idx_ff - VW'(1))
                                            : VAW'(ctrl.v - VW'(1));
   assign dist_wdata = (pend_ff == PK_SEED) ? {{(DW-WW){mat_rdata[WW-1]}}, mat_rdata}
                                            : best_ff;
   assign pred_wdata = (pend_ff == PK_SEED) ? '0 : bestp_ff;
   assign dist_raddr = (ctrl.rd_sel == bfsp_pkg::RD_DIST_V) ? VAW'(ctrl.v - VW'(1))
                                                            : VAW'(ctrl.u - VW'(1));
   assign pred_raddr = VAW'(ctrl.u - VW'(1));

   bfsp_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .raddr (dist_raddr),
      .rdata (dist_rdata)
   );

   bfsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pred (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (pred_wdata),
      .raddr (pred_raddr),
      .rdata (pred_rdata)
   );

   // track which read is in flight
   always_comb begin
      unique case (ctrl.rd_sel)
         bfsp_pkg::RD_SEED:  pend_in = PK_SEED;
         bfsp_pkg::RD_RELAX: pend_in = PK_RELAX;
         default:            pend_in = PK_NONE;
      endcase
   end

   // relaxation: the head's own entry lives in best_ff, not in the table
   always_comb begin
      du     = (pend_idx_ff == ctrl.v) ? best_ff : dist_rdata;
      usable = (mat_rdata != '0) && (mat_rdata != bfsp_pkg::INF_WGT) &&
               (du != bfsp_pkg::INF_DIST);
      sum    = {du[DW-1], du} + {{(DW+1-WW){mat_rdata[WW-1]}}, mat_rdata};
      if (sum[DW] != sum[DW-1]) begin
         sat = sum[DW] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
      end else begin
         sat = sum[DW-1:0];
      end

      best_in  = best_ff;
      bestp_in = bestp_ff;
      upd_in   = upd_ff;
      if (ctrl.load_best) begin
         best_in = dist_rdata;
         upd_in  = 1'b0;
      end else if ((pend_ff == PK_RELAX) && usable && ($signed(sat) < $signed(best_ff))) begin
         best_in  = sat;
         bestp_in = pend_idx_ff;
         upd_in   = 1'b1;
      end
   end

   // result register
   assign pred_out = (pred_rdata == '0) ? ctrl.s : pred_rdata;
   assign out_busy = rsp_valid_ff & ~rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}}, pred_out, dist_rdata, ctrl.u};
         rsp_last_in  = (ctrl.u == ctrl.n);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= PK_NONE;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= ctrl.u;
      best_ff     <= best_in;
      bestp_ff    <= bestp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/bellman_ford_shortest_paths_top.sv
// Single-source shortest paths (Bellman-Ford) over an adjacency-matrix store.
// req_*: stream of transactions. tuser = opcode: load writes one signed weight
//   at (row, col) into the matrix (0 = no edge, 999 = infinite); solve runs
//   the search from the configured source over the configured vertex count.
// rsp_*: one transaction per vertex 1..n after a solve, tlast on vertex n.
// csr_*: write channel for vertex_count (index 0) and source_vertex (index 1),
//   always ready; write only while no solve is in progress.
// Throughput: a load leaves the sequencer at the idle step and the next
//   transaction is taken on the following cycle. A solve is driven by a
//   microcoded sequencer through one read port per table, one tail vertex per
//   cycle in the inner loop; each result passes the ST_ORD and ST_OEMIT steps.
//   No new transaction is taken until the last result of a solve is loaded
//   into the output register.
// Reset: configuration returns to one vertex with source one; the matrix
//   contents are undefined until written.
// Stall: a result waits in the output register; the sequencer holds its emit
//   step while that result is pending and rsp_tready is low, losing nothing.
module bellman_ford_shortest_paths_top #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // tuser: opcode
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,
   // tdata: row_vertex[6:0], col_vertex[13:7], edge_weight[29:14], zero pad
   input  logic [bfsp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tdata: vertex_id[6:0], distance[30:7], predecessor[37:31], zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bfsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bfsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfsp_pkg::VID_W-1:0]          csr_data
);

   localparam int VW = bfsp_pkg::VID_W;

   logic [VW-1:0]         vertex_count_ff, vertex_count_in;
   logic [VW-1:0]         source_vertex_ff, source_vertex_in;
   logic                  out_busy;
   bfsp_pkg::dp_ctrl_type ctrl;

   // Configuration registers: the write channel never pushes back
   assign csr_ready = 1'b1;

   always_comb begin
      vertex_count_in  = vertex_count_ff;
      source_vertex_in = source_vertex_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bfsp_pkg::CSR_VERTEX_COUNT:  vertex_count_in  = csr_data;
            bfsp_pkg::CSR_SOURCE_VERTEX: source_vertex_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff  <= VW'(1);
         source_vertex_ff <= VW'(1);
      end else begin
         vertex_count_ff  <= vertex_count_in;
         source_vertex_ff <= source_vertex_in;
      end
   end

   // Sequencer: control store, step counter and loop counters
   bfsp_seq #(.MAX_VERTICES(MAX_VERTICES)) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_opcode        (req_tuser),
      .cfg_vertex_count  (vertex_count_ff),
      .cfg_source_vertex (source_vertex_ff),
      .out_busy          (out_busy),
      .ctrl              (ctrl)
   );

   // Input is taken only at the idle step of the program
   assign req_tready = ctrl.idle;

   // Datapath: matrix, distance and predecessor tables, relax unit, output stage
   bfsp_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .out_busy   (out_busy)
   );

endmodule

>>> test/tb_bellman_ford_shortest_paths_top.sv
module tb_bellman_ford_shortest_paths_top;

   localparam int VW            = bfsp_pkg::VID_W;
   localparam int WW            = bfsp_pkg::WGT_W;
   localparam int DW            = bfsp_pkg::DIST_W;
   localparam int IW            = bfsp_pkg::CSR_IDX_W;
   // Vertex range of the block as instantiated (default parameter).
   localparam int MAXV          = bfsp_pkg::MAX_VERTICES_DEFAULT;
   // Largest vertex count any solve uses; the matrix is filled up to this square.
   localparam int PRELOAD_N     = 8;
   // The "infinite" marker, both as a weight and as a distance.
   localparam int NO_PATH       = int'(bfsp_pkg::INF_WGT);
   // Saturation bounds of the 24-bit distance.
   localparam int DIST_TOP      = int'($signed(bfsp_pkg::DIST_MAX));
   localparam int DIST_BOTTOM   = int'($signed(bfsp_pkg::DIST_MIN));
   // Cycles to wait after the last result before touching the registers;
   // covers the sequencer's return to idle.
   localparam int SETTLE_CYCLES = 24;
   // Bound on the whole run, for the watchdog.
   localparam int CYCLE_LIMIT   = 400_000;
   localparam int RANDOM_ITEMS  = 76;

   // One request transaction: a weight load or a solve.
   typedef struct packed {
      logic          opcode;
      logic [VW-1:0] row;
      logic [VW-1:0] col;
      logic [WW-1:0] weight;
   } graph_op_type;

   // One result transaction: distance and predecessor of a vertex.
   typedef struct packed {
      logic [VW-1:0]        vertex;
      logic signed [DW-1:0] distance;
      logic [VW-1:0]        pred;
      logic                 last;
   } path_entry_type;

   typedef struct packed {
      logic [IW-1:0] index;
      logic [VW-1:0] value;
   } reg_write_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic                              req_tuser  = bfsp_pkg::OP_LOAD;
   logic [bfsp_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bfsp_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [IW-1:0]                     csr_index  = '0;
   logic [VW-1:0]                     csr_data   = '0;

   // Mirror of the block: weight matrix and the two registers (reset 1/1).
   logic signed [WW-1:0] weight_store [1:MAXV][1:MAXV];
   logic [VW-1:0]        cfg_count  = 7'd1;
   logic [VW-1:0]        cfg_source = 7'd1;

   graph_op_type   graph_ops[$];       // requests not yet accepted
   reg_write_type  reg_writes[$];      // register writes not yet accepted
   path_entry_type expected_paths[$];  // results predicted, not yet seen

   int   fault_count = 0;
   int   cycle_count = 0;
   int   req_gap     = 0;
   int   rsp_gap     = 0;
   logic idling_on   = 1'b1;

   bellman_ford_shortest_paths_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predict the results of a solve from the mirrored matrix and registers:
   // seed from the source row, relax n-1 rounds over every (tail, head) pair
   // with the head never the source, then list every vertex in order.
   function automatic void solve_paths();
      int             n, s, w, du, total;
      int             dist_of [1:MAXV];
      int             pred_of [1:MAXV];
      path_entry_type entry;
      n = cfg_count;
      if (n < 1) n = 1;
      if (n > MAXV) n = MAXV;
      s = cfg_source;
      if (s < 1) s = 1;
      if (s > n) s = n;
      for (int i = 1; i <= n; i++) begin
         dist_of[i] = weight_store[s][i];
         pred_of[i] = 0;
      end
      for (int k = 1; k < n; k++) begin
         for (int v = 1; v <= n; v++) begin
            if (v == s) continue;
            for (int u = 1; u <= n; u++) begin
               w  = weight_store[u][v];
               du = dist_of[u];
               // skip absent and infinite edges and unreached tails
               if (w == 0 || w == NO_PATH || du == NO_PATH) continue;
               total = du + w;
               if (total > DIST_TOP) total = DIST_TOP;
               if (total < DIST_BOTTOM) total = DIST_BOTTOM;
               if (total < dist_of[v]) begin
                  dist_of[v] = total;
                  pred_of[v] = u;
               end
            end
         end
      end
      for (int i = 1; i <= n; i++) begin
         entry.vertex   = VW'(i);
         entry.distance = DW'(dist_of[i]);
         // no predecessor recorded reports the source
         entry.pred     = VW'((pred_of[i] == 0) ? s : pred_of[i]);
         entry.last     = (i == n);
         expected_paths.push_back(entry);
      end
   endfunction

   // Weight mix: absent, infinite, short positive, short negative, any value,
   // the two extremes and longer positive edges.
   function automatic logic [WW-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         2:       return bfsp_pkg::INF_WGT;
         3, 4, 5: return WW'($urandom_range(1, 40));
         6:       return WW'(-int'($urandom_range(1, 6)));
         7:       return WW'($urandom);
         8:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return WW'($urandom_range(41, 2000));
      endcase
   endfunction

   task automatic push_load(input int row, input int col, input logic [WW-1:0] weight);
      graph_op_type op;
      op.opcode = bfsp_pkg::OP_LOAD;
      op.row    = VW'(row);
      op.col    = VW'(col);
      op.weight = weight;
      graph_ops.push_back(op);
   endtask

   // The load fields ride along on a solve with random content; the block
   // ignores them.
   task automatic push_solve();
      graph_op_type op;
      op.opcode = bfsp_pkg::OP_SOLVE;
      op.row    = VW'($urandom);
      op.col    = VW'($urandom);
      op.weight = WW'($urandom);
      graph_ops.push_back(op);
   endtask

   // Wait until every request is taken and every result is back, then give
   // the sequencer time to return to idle.
   task automatic settle();
      while (graph_ops.size() != 0 || expected_paths.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers while the block is idle.
   task automatic configure(input int count, input int source);
      reg_write_type wr;
      settle();
      wr.index = bfsp_pkg::CSR_VERTEX_COUNT;
      wr.value = VW'(count);
      reg_writes.push_back(wr);
      wr.index = bfsp_pkg::CSR_SOURCE_VERTEX;
      wr.value = VW'(source);
      reg_writes.push_back(wr);
      while (reg_writes.size() != 0) @(posedge clock);
   endtask

   // Request driver: on an accepted transaction, update the mirror or run the
   // prediction, then drop the item. Insert idle bursts only between items so
   // that tvalid never falls before its transaction is taken.
   always @(posedge clock) begin : op_driver
      logic         hold;
      graph_op_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         hold = req_tvalid;
         if (req_tvalid && req_tready) begin
            head = graph_ops.pop_front();
            if (head.opcode == bfsp_pkg::OP_SOLVE) begin
               solve_paths();
            end else if (head.row >= 1 && head.row <= MAXV &&
                         head.col >= 1 && head.col <= MAXV) begin
               weight_store[head.row][head.col] = head.weight;
            end
            hold = 1'b0;
         end
         if (!hold && graph_ops.size() != 0) begin
            if (req_gap != 0) begin
               req_gap = req_gap - 1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(0, 11);
            end else begin
               hold = 1'b1;
               req_tuser <= graph_ops[0].opcode;
               req_tdata <= {2'b00, graph_ops[0].weight, graph_ops[0].col, graph_ops[0].row};
            end
         end
         req_tvalid <= hold;
      end
   end

   // Register write driver: apply an accepted write to the mirror and present
   // the next one.
   always @(posedge clock) begin : reg_driver
      logic hold;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         hold = csr_valid;
         if (csr_valid && csr_ready) begin
            if (csr_index == bfsp_pkg::CSR_VERTEX_COUNT) cfg_count = csr_data;
            else cfg_source = csr_data;
            void'(reg_writes.pop_front());
            hold = 1'b0;
         end
         if (!hold && reg_writes.size() != 0) begin
            hold = 1'b1;
            csr_index <= reg_writes[0].index;
            csr_data  <= reg_writes[0].value;
         end
         csr_valid <= hold;
      end
   end

   // Result monitor: compare each accepted result with the oldest prediction,
   // and stall tready in random bursts.
   always @(posedge clock) begin : path_monitor
      path_entry_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.vertex   = rsp_tdata[6:0];
            got.distance = rsp_tdata[30:7];
            got.pred     = rsp_tdata[37:31];
            got.last     = rsp_tlast;
            if (expected_paths.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result: vertex %0d distance %0d pred %0d last %0d",
                           got.vertex, $signed(got.distance), got.pred, got.last);
            end else begin
               want = expected_paths.pop_front();
               if (got.vertex !== want.vertex || got.distance !== want.distance ||
                   got.pred !== want.pred || got.last !== want.last) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch: expected vertex %0d distance %0d pred %0d last %0d, %s",
                              want.vertex, $signed(want.distance), want.pred, want.last,
                              $sformatf("got vertex %0d distance %0d pred %0d last %0d",
                                        got.vertex, $signed(got.distance), got.pred,
                                        got.last));
               end
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap = rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_gap = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int            n_raw, n_eff, row, col, random_items;
      logic [WW-1:0] w;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: one vertex, source one; only entry (1,1) is read.
      push_load(1, 1, 16'd5);
      push_solve();
      settle();

      // Preload the square used by every later solve so that no solve reads
      // an unwritten entry. Lay a strongly negative ring 1->2->...->8->1 so
      // the solve keeps lowering distances around a negative cycle.
      for (int r = 1; r <= PRELOAD_N; r++) begin
         for (int c = 1; c <= PRELOAD_N; c++) begin
            if (c == r % PRELOAD_N + 1)
               w = (r == 1) ? 16'h8000 : WW'(-int'($urandom_range(20000, 32768)));
            else
               w = ($urandom_range(0, 9) == 0) ? pick_weight() : '0;
            push_load(r, c, w);
         end
      end
      // Loads outside the matrix: must leave every entry untouched.
      push_load(0, 1, 16'd7);
      push_load(1, 0, 16'hFFF9);
      push_load(65, 1, 16'd123);
      push_load(127, 127, 16'hFFFF);
      push_load(1, 65, 16'h5555);
      push_load(100, 3, bfsp_pkg::INF_WGT);

      // Source above the count clamps to the last vertex; also checks that
      // the ignored loads did no harm.
      configure(PRELOAD_N, 127);
      push_solve();

      // Four vertices, source clamped from 64 down to 4. Source row holds an
      // infinite entry (unreached seed) and a zero (seeds distance zero);
      // an infinite edge elsewhere is skipped.
      configure(4, 64);
      push_load(4, 1, bfsp_pkg::INF_WGT);
      push_load(4, 2, 16'd0);
      push_load(4, 3, 16'd7);
      push_load(3, 1, 16'h7FFF);
      push_load(1, 2, 16'h8000);
      push_load(2, 3, bfsp_pkg::INF_WGT);
      push_load(3, 3, 16'd0);
      push_solve();

      // Zero count and zero source act as one: no relaxation rounds.
      configure(0, 0);
      push_solve();

      // Two vertices with the source last.
      configure(2, 2);
      push_load(2, 2, 16'h8000);
      push_solve();

      // Random phases: small graphs, mostly loads inside the active square,
      // a few anywhere (including outside the matrix), then one or two solves.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         // hold off idling in the last stretch of the run
         idling_on = (random_items < RANDOM_ITEMS - 30) && ($urandom_range(0, 3) != 0);
         n_raw = $urandom_range(0, PRELOAD_N);
         n_eff = (n_raw < 1) ? 1 : n_raw;
         configure(n_raw, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(1, n_eff));
         repeat ($urandom_range(1, 2)) begin
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 6) == 0) begin
                  row = $urandom_range(0, 127);
                  col = $urandom_range(0, 127);
               end else begin
                  row = $urandom_range(1, n_eff);
                  col = $urandom_range(1, n_eff);
               end
               push_load(row, col, pick_weight());
               if (row >= 1 && row <= MAXV && col >= 1 && col <= MAXV) random_items++;
            end
            push_solve();
            random_items++;
         end
      end
      settle();

      if (fault_count == 0 && expected_paths.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/bfsp_pkg.sv
rtl/bfsp_ram.sv
rtl/bfsp_seq.sv
rtl/bfsp_dp.sv
rtl/bellman_ford_shortest_paths_top.sv
test/tb_bellman_ford_shortest_paths_top.sv
